### sv/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the power rail sequencer.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int unsigned DELAY_W = 16;
  localparam int unsigned CFG_W   = 16;

  typedef enum logic [2:0] {
    ST_OFF      = 3'd0,
    ST_BUCK_ON  = 3'd1,
    ST_SETTLE   = 3'd2,
    ST_ON       = 3'd3,
    ST_BUCK_OFF = 3'd4
  } seq_state_t;

  // transaction mode codes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;

  // configuration register indexes
  localparam logic CFG_SETTLE   = 1'b0;
  localparam logic CFG_BUCK_OFF = 1'b1;

  localparam logic [CFG_W-1:0] SETTLE_TICKS_RST   = 16'd50001;
  localparam logic [CFG_W-1:0] BUCK_OFF_TICKS_RST = 16'd50002;

  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

endpackage

### sv/power_rail_sequencer_top.sv
// ----------------------------------------------------------------------------
// power_rail_sequencer_top
// Five-state buck/receiver power sequencer with latched on/off requests.
// ----------------------------------------------------------------------------
//  channel | handshake                      | payload
//  --------+--------------------------------+-------------------------------
//  input   | in_valid / in_stall            | mode, buck_good
//  output  | out_valid / out_stall          | seq_state, buck_enable, rx_enable
//  config  | cfg_write                      | cfg_index, cfg_data
//
//  One transaction per clock while in_stall is low: the state updates on the
//  accepting edge and the result lands in the output register (the skid if
//  stalled) the same edge. A skid register behind the output register keeps
//  input flowing for one extra transaction while the output is stalled; in_stall is the skid full.
//  Synchronous active-high rst returns to off with both requests cleared and
//  the delay registers at their defaults.
// ----------------------------------------------------------------------------
module power_rail_sequencer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic                      buck_good,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                seq_state,
  output logic                      buck_enable,
  output logic                      rx_enable,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [prs_pkg::CFG_W-1:0] cfg_data
);
  import prs_pkg::*;

  logic [CFG_W-1:0]   settle_ticks;
  logic [CFG_W-1:0]   buck_off_ticks;

  seq_state_t         seq_code, seq_next;
  logic               on_pending, on_pending_next;
  logic               off_pending, off_pending_next;
  logic [DELAY_W-1:0] delay_count, delay_next;
  logic [DELAY_W-1:0] count_inc;
  logic               settle_done, off_done;
  logic               buck_next, rx_next;

  logic               skid_valid;
  logic [2:0]         skid_state;
  logic               skid_buck, skid_rx;

  logic               in_accept, out_free;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks   <= SETTLE_TICKS_RST;
      buck_off_ticks <= BUCK_OFF_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SETTLE:   settle_ticks   <= cfg_data;
        CFG_BUCK_OFF: buck_off_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating count; a limit of zero ends the wait on the first tick
  assign count_inc   = (delay_count != DELAY_MAX) ? delay_count + 1'b1 : delay_count;
  assign settle_done = count_inc >= settle_ticks;
  assign off_done    = count_inc >= buck_off_ticks;

  // next state
  always_comb begin
    seq_next         = seq_code;
    on_pending_next  = on_pending;
    off_pending_next = off_pending;
    delay_next       = delay_count;
    case (mode)
      MODE_ON: begin
        on_pending_next  = 1'b1;
        off_pending_next = 1'b0;
      end
      MODE_OFF: begin
        on_pending_next  = 1'b0;
        off_pending_next = 1'b1;
      end
      MODE_TICK: begin
        case (seq_code)
          ST_OFF: begin
            if (off_pending) begin
              off_pending_next = 1'b0;
            end else if (on_pending) begin
              on_pending_next = 1'b0;
              seq_next        = ST_BUCK_ON;
            end
          end
          ST_BUCK_ON: begin
            if (off_pending) begin
              off_pending_next = 1'b0;
              seq_next         = ST_BUCK_OFF;
              delay_next       = '0;
            end else if (on_pending) begin
              on_pending_next = 1'b0;
            end else if (buck_good) begin
              seq_next   = ST_SETTLE;
              delay_next = '0;
            end
          end
          ST_SETTLE: begin
            if (off_pending) begin
              off_pending_next = 1'b0;
              seq_next         = ST_BUCK_OFF;
              delay_next       = '0;
            end else if (on_pending) begin
              on_pending_next = 1'b0;
            end else if (settle_done) begin
              seq_next   = ST_ON;
              delay_next = '0;
            end else begin
              delay_next = count_inc;
            end
          end
          ST_ON: begin
            if (off_pending) begin
              off_pending_next = 1'b0;
              seq_next         = ST_BUCK_OFF;
              delay_next       = '0;
            end else if (on_pending) begin
              on_pending_next = 1'b0;
            end
          end
          ST_BUCK_OFF: begin
            if (off_pending) begin
              off_pending_next = 1'b0;
            end else if (on_pending) begin
              on_pending_next = 1'b0;
              seq_next        = ST_SETTLE;
              delay_next      = '0;
            end else if (off_done) begin
              seq_next   = ST_OFF;
              delay_next = '0;
            end else begin
              delay_next = count_inc;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // enables are a decode of the state after the step
  always_comb begin
    case (seq_next)
      ST_OFF: begin
        buck_next = 1'b0;
        rx_next   = 1'b0;
      end
      ST_BUCK_ON, ST_BUCK_OFF: begin
        buck_next = 1'b1;
        rx_next   = 1'b0;
      end
      ST_SETTLE, ST_ON: begin
        buck_next = 1'b1;
        rx_next   = 1'b1;
      end
      default: begin
        buck_next = 1'b0;
        rx_next   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_code    <= ST_OFF;
      on_pending  <= 1'b0;
      off_pending <= 1'b0;
      delay_count <= '0;
    end else if (in_accept) begin
      seq_code    <= seq_next;
      on_pending  <= on_pending_next;
      off_pending <= off_pending_next;
      delay_count <= delay_next;
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        seq_state   <= skid_state;
        buck_enable <= skid_buck;
        rx_enable   <= skid_rx;
      end else if (in_accept) begin
        seq_state   <= seq_next;
        buck_enable <= buck_next;
        rx_enable   <= rx_next;
      end
    end else if (in_accept) begin
      skid_state <= seq_next;
      skid_buck  <= buck_next;
      skid_rx    <= rx_next;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_pending_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(on_pending && off_pending))
    else $error("on and off requests pending together");

  a_count_in_wait: assert property (@(posedge clk) disable iff (rst)
    (delay_count != '0) |-> (seq_code == ST_SETTLE || seq_code == ST_BUCK_OFF))
    else $error("delay counter nonzero outside a wait state");

  a_stalled_accept_to_skid: assert property (@(posedge clk) disable iff (rst)
    (in_accept && out_valid && out_stall) |=> skid_valid)
    else $error("transaction accepted under stall not captured in skid");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for power_rail_sequencer_top: a behavioral tracker of
// the sequencer predicts the status after every accepted transaction, and
// each output transaction is compared field by field, in order. Directed
// boot, shutdown and abort sequences come first, then full-range delay
// limits cut short by requests, then random request/tick traffic under four
// idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
  import prs_pkg::*;

  localparam logic [1:0] MODE_NONE  = 2'd3;  // unused code, ignored by the block
  localparam int         STUCK_LIMIT = 2000;

  typedef struct {
    seq_state_t st;
    logic       buck;
    logic       rx;
  } rail_status_t;

  class rail_tracker;
    int unsigned          errors;
    rail_status_t         status_q[$];
    logic [CFG_W-1:0]     settle_lim;
    logic [CFG_W-1:0]     buck_off_lim;
    seq_state_t           st;
    bit                   on_req;
    bit                   off_req;
    logic [DELAY_W-1:0]   delay;
    bit                   buck;
    bit                   rx;

    function new();
      errors       = 0;
      settle_lim   = SETTLE_TICKS_RST;
      buck_off_lim = BUCK_OFF_TICKS_RST;
      st           = ST_OFF;
      on_req       = 0;
      off_req      = 0;
      delay        = '0;
      buck         = 0;
      rx           = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_SETTLE) settle_lim = val;
      else buck_off_lim = val;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void enter_wait(seq_state_t nxt);
      st    = nxt;
      delay = '0;
    endfunction

    // saturating count; wait ends once the count meets the limit
    function bit delay_done(logic [CFG_W-1:0] lim);
      if (delay != DELAY_MAX) delay = delay + 1'b1;
      if (delay >= lim) begin
        delay = '0;
        return 1;
      end
      return 0;
    endfunction

    function void update_tick(bit good);
      case (st)
        ST_OFF: begin
          if (off_req) off_req = 0;
          else if (on_req) begin
            on_req = 0;
            buck   = 1;
            st     = ST_BUCK_ON;
          end
        end
        ST_BUCK_ON: begin
          if (off_req) begin
            off_req = 0;
            enter_wait(ST_BUCK_OFF);
          end else if (on_req) on_req = 0;
          else if (good) begin
            rx = 1;
            enter_wait(ST_SETTLE);
          end
        end
        ST_SETTLE: begin
          if (off_req) begin
            off_req = 0;
            rx      = 0;
            enter_wait(ST_BUCK_OFF);
          end else if (on_req) on_req = 0;
          else if (delay_done(settle_lim)) st = ST_ON;
        end
        ST_ON: begin
          if (off_req) begin
            off_req = 0;
            rx      = 0;
            enter_wait(ST_BUCK_OFF);
          end else if (on_req) on_req = 0;
        end
        ST_BUCK_OFF: begin
          if (off_req) off_req = 0;
          else if (on_req) begin
            on_req = 0;
            rx     = 1;
            enter_wait(ST_SETTLE);
          end else if (delay_done(buck_off_lim)) begin
            buck = 0;
            st   = ST_OFF;
          end
        end
        default: ;
      endcase
    endfunction

    function void take_request(logic [1:0] m, logic good);
      rail_status_t s;
      case (m)
        MODE_TICK: update_tick(good);
        MODE_ON: begin
          on_req  = 1;
          off_req = 0;
        end
        MODE_OFF: begin
          on_req  = 0;
          off_req = 1;
        end
        default: ;
      endcase
      s.st   = st;
      s.buck = buck;
      s.rx   = rx;
      status_q.push_back(s);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task match_status(logic [2:0] seq, logic be, logic re);
      rail_status_t exp;
      if (status_q.size() == 0) begin
        report("output transaction with nothing expected");
        return;
      end
      exp = status_q.pop_front();
      if (seq !== exp.st)
        report($sformatf("seq_state %0d, expected %0d", seq, exp.st));
      if (be !== exp.buck)
        report($sformatf("buck_enable %b, expected %b", be, exp.buck));
      if (re !== exp.rx)
        report($sformatf("rx_enable %b, expected %b", re, exp.rx));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic               buck_good;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         seq_state;
  logic               buck_enable;
  logic               rx_enable;
  logic               cfg_write;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  rail_tracker trk = new();
  int          gap_pct;
  int          stall_pct;
  int          stuck_cycles;

  power_rail_sequencer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .buck_good   (buck_good),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .seq_state   (seq_state),
    .buck_enable (buck_enable),
    .rx_enable   (rx_enable),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  // receiver side backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) trk.take_request(mode, buck_good);
      if (out_valid && !out_stall) trk.match_status(seq_state, buck_enable, rx_enable);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(input logic [1:0] m, input logic g);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    buck_good <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    int          r;
    logic [1:0]  m;
    r = $urandom_range(99);
    if (r < 70) m = MODE_TICK;
    else if (r < 82) m = MODE_ON;
    else if (r < 94) m = MODE_OFF;
    else m = MODE_NONE;
    send(m, $urandom_range(99) < 60);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (trk.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    trk.set_reg(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic ticks(input int n, input logic g);
    repeat (n) send(MODE_TICK, g);
  endtask

  initial begin
    int profile;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_TICK;
    buck_good    = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = CFG_SETTLE;
    cfg_data     = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: boot, redundant requests, aborts, newest request wins
    write_reg(CFG_SETTLE, 16'd3);
    write_reg(CFG_BUCK_OFF, 16'd2);
    send(MODE_TICK, 1'b0);
    send(MODE_NONE, 1'b1);
    send(MODE_OFF, 1'b0);
    send(MODE_TICK, 1'b1);
    send(MODE_ON, 1'b1);
    send(MODE_TICK, 1'b1);
    send(MODE_TICK, 1'b0);
    send(MODE_ON, 1'b0);
    send(MODE_TICK, 1'b1);
    send(MODE_TICK, 1'b1);
    send(MODE_TICK, 1'b0);
    send(MODE_NONE, 1'b0);
    send(MODE_TICK, 1'b0);
    send(MODE_TICK, 1'b1);
    send(MODE_OFF, 1'b1);
    send(MODE_TICK, 1'b0);
    send(MODE_ON, 1'b0);
    send(MODE_TICK, 1'b0);
    send(MODE_OFF, 1'b0);
    send(MODE_TICK, 1'b1);
    ticks(2, 1'b1);
    send(MODE_ON, 1'b0);
    send(MODE_OFF, 1'b0);
    send(MODE_TICK, 1'b1);
    drain();

    // zero delays end on the first counting tick
    write_reg(CFG_SETTLE, 16'd0);
    write_reg(CFG_BUCK_OFF, 16'd0);
    send(MODE_ON, 1'b0);
    ticks(3, 1'b1);
    send(MODE_OFF, 1'b0);
    ticks(2, 1'b0);
    drain();

    // shorten the turn-off delay mid-wait: count already past the new limit
    write_reg(CFG_BUCK_OFF, 16'd10);
    send(MODE_ON, 1'b0);
    send(MODE_TICK, 1'b0);
    send(MODE_OFF, 1'b0);
    ticks(5, 1'b0);
    drain();
    write_reg(CFG_BUCK_OFF, 16'd3);
    ticks(2, 1'b0);
    drain();

    // full-range limits: waits cut short by requests
    write_reg(CFG_SETTLE, 16'hFFFF);
    write_reg(CFG_BUCK_OFF, 16'hFFFF);
    send(MODE_ON, 1'b0);
    ticks(2, 1'b1);
    ticks(10, 1'b0);
    send(MODE_OFF, 1'b0);
    ticks(10, 1'b1);
    send(MODE_ON, 1'b0);
    send(MODE_TICK, 1'b0);
    drain();

    // random traffic under each idling profile
    for (profile = 0; profile < 4; profile++) begin
      case (profile)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
          write_reg(CFG_SETTLE, 16'd1);
          write_reg(CFG_BUCK_OFF, 16'd1);
        end
        1: begin
          gap_pct   = 50;
          stall_pct = 0;
          write_reg(CFG_SETTLE, 16'($urandom_range(6, 2)));
          write_reg(CFG_BUCK_OFF, 16'($urandom_range(6, 2)));
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 50;
          write_reg(CFG_SETTLE, 16'($urandom_range(12, 1)));
          write_reg(CFG_BUCK_OFF, 16'd0);
        end
        default: begin
          gap_pct   = 26;
          stall_pct = 26;
          write_reg(CFG_SETTLE, 16'($urandom_range(4, 0)));
          write_reg(CFG_BUCK_OFF, 16'($urandom_range(12, 1)));
        end
      endcase
      repeat (85) send_random();
      drain();
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (trk.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
